/* hdl/cdo_pkg.sv */
// Package for the calendar date-time offset block: field widths, payload structs,
// register indexes and the leap-year / month-length helpers.
// No dependencies.
package cdo_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MON_W   = 4;
   localparam int unsigned YEAR_W  = 12;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned OFS_W   = 17;
   localparam int unsigned TOD_W   = 17;
   localparam int unsigned CSR_IDX_W = 1;

   localparam int unsigned MAX_OFFSET_DEF = 86400;

   localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd1900;
   localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2030;

   localparam logic [TOD_W-1:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [TOD_W-1:0] SECS_PER_MIN  = 17'd60;

   localparam logic [HOUR_W-1:0] LAST_HOUR   = 5'd23;
   localparam logic [MIN_W-1:0]  LAST_MINUTE = 6'd59;
   localparam logic [SEC_W-1:0]  LAST_SECOND = 6'd59;

   localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_YEAR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_YEAR = 1'b1;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;

   typedef struct packed {
      logic              op;
      logic [DAY_W-1:0]  day;
      logic [MON_W-1:0]  month;
      logic [YEAR_W-1:0] year;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
      logic [OFS_W-1:0]  offset_seconds;
   } req_type;

   typedef struct packed {
      logic [DAY_W-1:0]  out_day;
      logic [MON_W-1:0]  out_month;
      logic [YEAR_W-1:0] out_year;
      logic [HOUR_W-1:0] out_hour;
      logic [MIN_W-1:0]  out_minute;
      logic [SEC_W-1:0]  out_second;
      logic              input_ok;
   } rsp_type;

   // 400/100/4 rule; y/4 divided by 25 through a reciprocal, exact below 1024
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [9:0]  x;
      logic [19:0] p;
      logic [9:0]  q;
      logic [9:0]  q25;
      logic        div100;
      logic        div400;
      x      = y[11:2];
      p      = {10'b0, x} * 20'd41;
      q      = p[19:10];
      q25    = q * 10'd25;
      div100 = (y[1:0] == 2'b00) && (x == q25);
      div400 = div100 && (y[3:0] == 4'b0000);
      return div400 || ((y[1:0] == 2'b00) && !div100);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] d;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         MONTH_FEB: d = leap ? 5'd29 : 5'd28;
         default: d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

/* hdl/calendar_datetime_offset.sv */
// Top level of the calendar date-time offset block: input register, validity
// and day-carry stages, then the time-of-day split. Depends on cdo_pkg, cdo_tod_split.
//
// Usage:
//   Input: an item on req_data is taken at a rising edge with start high and
//   busy low. busy is high only while reset is asserted, so one item can be
//   taken every cycle.
//   Result: rsp_data is shown with rsp_valid high for one cycle once the item
//   has passed the pipeline, and is taken in that cycle. The accept edge
//   loads the input register; four register stages follow:
//   validity/time-of-day, day carry, hour split, minute/second split.
//   Throughput is one item per cycle; results come out in input order.
//   The receiver cannot stall the block; every result must be taken.
//   Invalid input (field out of range, year outside the programmed bounds,
//   offset above MAX_OFFSET) returns the input date and time with
//   input_ok low.
//   Registers: csr_index selects min year (0) or max year (1), written with
//   csr_we; they reset to 1900 and 2030. Write them only while idle.
//   Reset: synchronous; clears all valid flags, nothing in flight survives.
module calendar_datetime_offset #(
   parameter int unsigned MAX_OFFSET = cdo_pkg::MAX_OFFSET_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  cdo_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output cdo_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [cdo_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cdo_pkg::YEAR_W-1:0]   csr_wdata
);
   import cdo_pkg::*;

   localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_OFFSET);

   logic [YEAR_W-1:0] min_year_ff;
   logic [YEAR_W-1:0] max_year_ff;

   logic              in_valid_ff;
   req_type           in_req_ff;

   logic              leap;
   logic [MON_W-1:0]  prev_month;
   logic [DAY_W-1:0]  mdays_in;
   logic [DAY_W-1:0]  pdays_in;
   logic              ok_in;
   logic [TOD_W-1:0]  tod_in;

   logic              s2_valid_ff;
   req_type           s2_req_ff;
   logic              s2_ok_ff;
   logic [TOD_W-1:0]  s2_tod_ff;
   logic [DAY_W-1:0]  s2_mdays_ff;
   logic [DAY_W-1:0]  s2_pdays_ff;

   logic [TOD_W:0]    add_sum;
   logic              add_wrap;
   logic              sub_borrow;
   logic [TOD_W-1:0]  tod_new;
   rsp_type           s3_rsp_in;

   logic              s3_valid_ff;
   rsp_type           s3_rsp_ff;
   logic [TOD_W-1:0]  s3_tod_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff <= MIN_YEAR_RST;
         max_year_ff <= MAX_YEAR_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_YEAR: min_year_ff <= csr_wdata;
            CSR_MAX_YEAR: max_year_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      in_req_ff <= req_data;
   end

   // validity, month lengths, time of day in seconds
   always_comb begin
      leap       = is_leap(in_req_ff.year);
      prev_month = (in_req_ff.month == MONTH_JAN) ? MONTH_DEC : in_req_ff.month - 4'd1;
      mdays_in   = month_days(in_req_ff.month, leap);
      pdays_in   = month_days(prev_month, leap);
      ok_in      = (in_req_ff.hour <= LAST_HOUR) && (in_req_ff.minute <= LAST_MINUTE)
                   && (in_req_ff.second <= LAST_SECOND)
                   && (in_req_ff.month >= MONTH_JAN) && (in_req_ff.month <= MONTH_DEC)
                   && (in_req_ff.day != 5'd0) && (in_req_ff.day <= mdays_in)
                   && (in_req_ff.year >= min_year_ff) && (in_req_ff.year <= max_year_ff)
                   && (in_req_ff.offset_seconds <= MAX_OFS);
      tod_in     = {12'b0, in_req_ff.hour} * SECS_PER_HOUR
                   + {11'b0, in_req_ff.minute} * SECS_PER_MIN
                   + {11'b0, in_req_ff.second};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid_ff;
      end
      s2_req_ff   <= in_req_ff;
      s2_ok_ff    <= ok_in;
      s2_tod_ff   <= tod_in;
      s2_mdays_ff <= mdays_in;
      s2_pdays_ff <= pdays_in;
   end

   // offset and at most one day boundary
   always_comb begin
      add_sum    = {1'b0, s2_tod_ff} + {1'b0, s2_req_ff.offset_seconds};
      add_wrap   = add_sum >= {1'b0, SECS_PER_DAY};
      sub_borrow = s2_tod_ff < s2_req_ff.offset_seconds;

      s3_rsp_in.out_day    = s2_req_ff.day;
      s3_rsp_in.out_month  = s2_req_ff.month;
      s3_rsp_in.out_year   = s2_req_ff.year;
      s3_rsp_in.out_hour   = s2_req_ff.hour;
      s3_rsp_in.out_minute = s2_req_ff.minute;
      s3_rsp_in.out_second = s2_req_ff.second;
      s3_rsp_in.input_ok   = s2_ok_ff;

      if (s2_req_ff.op == OP_ADD) begin
         tod_new = add_wrap ? add_sum[TOD_W-1:0] - SECS_PER_DAY : add_sum[TOD_W-1:0];
      end else begin
         tod_new = sub_borrow ? s2_tod_ff + SECS_PER_DAY - s2_req_ff.offset_seconds
                              : s2_tod_ff - s2_req_ff.offset_seconds;
      end

      if (s2_ok_ff) begin
         if (s2_req_ff.op == OP_ADD) begin
            if (add_wrap) begin
               if (s2_req_ff.day == s2_mdays_ff) begin
                  s3_rsp_in.out_day = 5'd1;
                  if (s2_req_ff.month == MONTH_DEC) begin
                     s3_rsp_in.out_month = MONTH_JAN;
                     s3_rsp_in.out_year  = s2_req_ff.year + 12'd1;
                  end else begin
                     s3_rsp_in.out_month = s2_req_ff.month + 4'd1;
                  end
               end else begin
                  s3_rsp_in.out_day = s2_req_ff.day + 5'd1;
               end
            end
         end else if (sub_borrow) begin
            if (s2_req_ff.day > 5'd1) begin
               s3_rsp_in.out_day = s2_req_ff.day - 5'd1;
            end else begin
               s3_rsp_in.out_day = s2_pdays_ff;
               if (s2_req_ff.month == MONTH_JAN) begin
                  s3_rsp_in.out_month = MONTH_DEC;
                  s3_rsp_in.out_year  = s2_req_ff.year - 12'd1;
               end else begin
                  s3_rsp_in.out_month = s2_req_ff.month - 4'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_rsp_ff <= s3_rsp_in;
      s3_tod_ff <= tod_new;
   end

   cdo_tod_split u_tod_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_rsp    (s3_rsp_ff),
      .in_tod    (s3_tod_ff),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

`ifndef ASSERT_OFF
   a_rsp_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result without a matching input transfer");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.input_ok |->
         rsp_data.out_hour <= LAST_HOUR && rsp_data.out_minute <= LAST_MINUTE
         && rsp_data.out_second <= LAST_SECOND)
      else $error("time of day out of range on valid result");

   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.input_ok |->
         rsp_data.out_month >= MONTH_JAN && rsp_data.out_month <= MONTH_DEC
         && rsp_data.out_day != 5'd0)
      else $error("date out of range on valid result");

   a_invalid_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.input_ok |->
         rsp_data.out_day == $past(req_data.day, 5)
         && rsp_data.out_hour == $past(req_data.hour, 5)
         && rsp_data.out_second == $past(req_data.second, 5))
      else $error("invalid input not echoed");
`endif

endmodule

/* hdl/cdo_tod_split.sv */
// Two-stage split of a time of day in seconds into hour, minute and second.
// Depends on cdo_pkg.
module cdo_tod_split (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  cdo_pkg::rsp_type         in_rsp,
   input  logic [cdo_pkg::TOD_W-1:0] in_tod,
   output logic                     out_valid,
   output cdo_pkg::rsp_type         out_rsp
);
   import cdo_pkg::*;

   logic [25:0]        hour_prod;
   logic [31:0]        tmin_prod;
   logic [HOUR_W-1:0]  hour_in;
   logic [10:0]        tmin_in;

   logic               a_valid_ff;
   rsp_type            a_rsp_ff;
   logic [TOD_W-1:0]   a_tod_ff;
   logic [HOUR_W-1:0]  a_hour_ff;
   logic [10:0]        a_tmin_ff;

   logic [10:0]        hour_min;
   logic [10:0]        minute_full;
   logic [TOD_W-1:0]   tmin_sec;
   logic [TOD_W-1:0]   second_full;

   logic               out_valid_ff;
   rsp_type            out_rsp_ff;
   rsp_type            out_rsp_in;

   // tod/3600 = (tod>>4)/225 and tod/60 = (tod>>2)/15, both exact below one day
   always_comb begin
      hour_prod = {13'b0, in_tod[16:4]} * 26'd4661;
      tmin_prod = {17'b0, in_tod[16:2]} * 32'd69906;
      hour_in   = hour_prod[24:20];
      tmin_in   = tmin_prod[30:20];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_rsp_ff  <= in_rsp;
      a_tod_ff  <= in_tod;
      a_hour_ff <= hour_in;
      a_tmin_ff <= tmin_in;
   end

   always_comb begin
      hour_min    = {6'b0, a_hour_ff} * 11'd60;
      minute_full = a_tmin_ff - hour_min;
      tmin_sec    = {6'b0, a_tmin_ff} * SECS_PER_MIN;
      second_full = a_tod_ff - tmin_sec;
      out_rsp_in  = a_rsp_ff;
      if (a_rsp_ff.input_ok) begin
         out_rsp_in.out_hour   = a_hour_ff;
         out_rsp_in.out_minute = minute_full[MIN_W-1:0];
         out_rsp_in.out_second = second_full[SEC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= a_valid_ff;
      end
      out_rsp_ff <= out_rsp_in;
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

endmodule

/* tb/sv/tb_calendar_datetime_offset.sv */
`timescale 1ns / 1ps
// Self-checking bench for calendar_datetime_offset: directed and random date-time shifts,
// checked against an in-bench calendar predictor over several year-bound settings.
// Depends on cdo_pkg and the calendar_datetime_offset RTL.
module tb_calendar_datetime_offset;
   import cdo_pkg::*;

   localparam int unsigned LATENCY     = 5;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned OFFSET_CAP  = MAX_OFFSET_DEF;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_YEAR;
   logic [YEAR_W-1:0]    csr_wdata = '0;

   req_type     datetimes_to_send[$];
   rsp_type     shifted_due[$];
   int unsigned year_floor   = MIN_YEAR_RST;
   int unsigned year_ceiling = MAX_YEAR_RST;
   int unsigned sent, checked, rejected, settings, errors, stall;

   calendar_datetime_offset dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit leap_year(input int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
      if (m < MONTH_JAN || m > MONTH_DEC) return 0;
      if (m == MONTH_FEB) return leap_year(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
   endfunction

   function automatic rsp_type shift_datetime(input req_type r);
      rsp_type     o;
      int unsigned d, mo, y, t, n;
      bit          ok;
      d  = r.day;
      mo = r.month;
      y  = r.year;
      n  = r.offset_seconds;
      ok = r.hour <= LAST_HOUR && r.minute <= LAST_MINUTE && r.second <= LAST_SECOND
         && mo >= MONTH_JAN && mo <= MONTH_DEC && d >= 1 && d <= month_length(mo, y)
         && y >= year_floor && y <= year_ceiling && n <= OFFSET_CAP;
      o.out_hour   = r.hour;
      o.out_minute = r.minute;
      o.out_second = r.second;
      if (ok) begin
         t = r.hour * 3600 + r.minute * 60 + r.second;
         if (r.op == OP_ADD) begin
            t = t + n;
            if (t >= SECS_PER_DAY) begin
               t = t - SECS_PER_DAY;
               d++;
               if (d > month_length(mo, y)) begin
                  d = 1;
                  mo++;
                  if (mo > MONTH_DEC) begin
                     mo = MONTH_JAN;
                     y  = (y + 1) % 4096;
                  end
               end
            end
         end else if (t < n) begin
            t = t + SECS_PER_DAY - n;
            if (d > 1) begin
               d--;
            end else begin
               if (mo > MONTH_JAN) begin
                  mo--;
               end else begin
                  mo = MONTH_DEC;
                  y  = (y + 4095) % 4096;
               end
               d = month_length(mo, y);
            end
         end else begin
            t = t - n;
         end
         o.out_hour   = HOUR_W'(t / 3600);
         o.out_minute = MIN_W'((t / 60) % 60);
         o.out_second = SEC_W'(t % 60);
      end
      o.out_day   = DAY_W'(d);
      o.out_month = MON_W'(mo);
      o.out_year  = YEAR_W'(y);
      o.input_ok  = ok;
      return o;
   endfunction

   function automatic req_type stamp(input logic op, input int unsigned d, input int unsigned mo,
                                     input int unsigned y, input int unsigned h,
                                     input int unsigned mi, input int unsigned s,
                                     input int unsigned n);
      req_type r;
      r.op             = op;
      r.day            = DAY_W'(d);
      r.month          = MON_W'(mo);
      r.year           = YEAR_W'(y);
      r.hour           = HOUR_W'(h);
      r.minute         = MIN_W'(mi);
      r.second         = SEC_W'(s);
      r.offset_seconds = OFS_W'(n);
      return r;
   endfunction

   // mostly well-formed, biased to month ends and midnight; the rest raw noise
   function automatic req_type random_datetime();
      logic [63:0] raw;
      req_type     r;
      int unsigned dim;
      raw = {$urandom(), $urandom()};
      r   = raw[$bits(req_type)-1:0];
      if ($urandom_range(99) < 15) return r;
      if (year_floor <= year_ceiling) begin
         case ($urandom_range(9))
            0: r.year = YEAR_W'(year_floor);
            1: r.year = YEAR_W'(year_ceiling);
            default: r.year = YEAR_W'($urandom_range(year_ceiling, year_floor));
         endcase
      end
      r.month = MON_W'($urandom_range(MONTH_DEC, MONTH_JAN));
      dim = month_length(r.month, r.year);
      case ($urandom_range(9))
         0, 1, 2: r.day = DAY_W'(dim);
         3: r.day = 5'd1;
         default: r.day = DAY_W'($urandom_range(dim, 1));
      endcase
      r.hour   = HOUR_W'($urandom_range(LAST_HOUR));
      r.minute = MIN_W'($urandom_range(LAST_MINUTE));
      r.second = SEC_W'($urandom_range(LAST_SECOND));
      case ($urandom_range(9))
         0: {r.hour, r.minute} = {LAST_HOUR, LAST_MINUTE};
         1: {r.hour, r.minute} = '0;
         default: ;
      endcase
      case ($urandom_range(9))
         0: r.offset_seconds = OFS_W'(OFFSET_CAP);
         1: r.offset_seconds = OFS_W'($urandom_range(60));
         default: r.offset_seconds = OFS_W'($urandom_range(OFFSET_CAP));
      endcase
      return r;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= YEAR_W'(val);
      if (idx == CSR_MIN_YEAR) year_floor = val;
      else year_ceiling = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (datetimes_to_send.size() != 0 || shifted_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) datetimes_to_send.push_back(random_datetime());
   endtask

   // driver: one transfer per edge where start is high and busy low
   always @(posedge clock) begin : drive_proc
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            shifted_due.push_back(shift_datetime(req_data));
            void'(datetimes_to_send.pop_front());
            sent++;
         end
         go = datetimes_to_send.size() != 0
            && ((sent >= 600 && sent < 900) || $urandom_range(99) >= 15);
         start <= go;
         if (go) req_data <= datetimes_to_send[0];
      end
   end

   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (shifted_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: result with none due: %0d-%0d-%0d %0d:%0d:%0d ok=%0b",
                        rsp_data.out_year, rsp_data.out_month, rsp_data.out_day,
                        rsp_data.out_hour, rsp_data.out_minute, rsp_data.out_second,
                        rsp_data.input_ok);
         end else begin
            want = shifted_due.pop_front();
            checked++;
            if (!want.input_ok) rejected++;
            if (rsp_data.out_day !== want.out_day || rsp_data.out_month !== want.out_month
                || rsp_data.out_year !== want.out_year || rsp_data.out_hour !== want.out_hour
                || rsp_data.out_minute !== want.out_minute
                || rsp_data.out_second !== want.out_second
                || rsp_data.input_ok !== want.input_ok) begin
               errors++;
               if (errors <= 10) begin
                  $display("ERROR: result %0d exp %0d-%0d-%0d %0d:%0d:%0d ok=%0b",
                           checked, want.out_year, want.out_month, want.out_day,
                           want.out_hour, want.out_minute, want.out_second,
                           want.input_ok);
                  $display("       got %0d-%0d-%0d %0d:%0d:%0d ok=%0b",
                           rsp_data.out_year, rsp_data.out_month, rsp_data.out_day,
                           rsp_data.out_hour, rsp_data.out_minute, rsp_data.out_second,
                           rsp_data.input_ok);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall <= 0;
      else stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : main_proc
      int unsigned lo, hi;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset bounds 1900..2030: carries, leap rule, range limits
      datetimes_to_send.push_back(stamp(OP_ADD, 31, 12, 2030, 23, 59, 59, 1));
      datetimes_to_send.push_back(stamp(OP_SUB, 1, 1, 1900, 0, 0, 0, 1));
      datetimes_to_send.push_back(stamp(OP_ADD, 28, 2, 2000, 12, 0, 0, 86400));
      datetimes_to_send.push_back(stamp(OP_ADD, 28, 2, 1900, 23, 0, 0, 3600));
      datetimes_to_send.push_back(stamp(OP_SUB, 1, 3, 2000, 0, 0, 0, 1));
      datetimes_to_send.push_back(stamp(OP_SUB, 1, 3, 2001, 0, 0, 10, 86400));
      datetimes_to_send.push_back(stamp(OP_ADD, 15, 6, 1950, 10, 20, 30, 0));
      datetimes_to_send.push_back(stamp(OP_SUB, 15, 6, 1950, 23, 59, 59, 86400));
      datetimes_to_send.push_back(stamp(OP_ADD, 30, 2, 2000, 1, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_ADD, 29, 2, 1999, 1, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_ADD, 29, 2, 2004, 23, 59, 0, 60));
      datetimes_to_send.push_back(stamp(OP_ADD, 31, 4, 2010, 1, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_ADD, 30, 4, 2010, 23, 0, 0, 7200));
      datetimes_to_send.push_back(stamp(OP_ADD, 10, 5, 2010, 24, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_SUB, 10, 5, 2010, 31, 63, 63, 5));
      datetimes_to_send.push_back(stamp(OP_ADD, 10, 5, 2010, 5, 60, 60, 5));
      datetimes_to_send.push_back(stamp(OP_ADD, 10, 0, 2010, 5, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_ADD, 10, 13, 2010, 5, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_SUB, 31, 15, 2010, 5, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_ADD, 0, 1, 2010, 5, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_ADD, 31, 1, 2010, 5, 0, 0, 86401));
      datetimes_to_send.push_back(stamp(OP_SUB, 31, 1, 2010, 5, 0, 0, 131071));
      datetimes_to_send.push_back(stamp(OP_ADD, 31, 12, 1899, 5, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_ADD, 1, 1, 2031, 5, 0, 0, 5));
      datetimes_to_send.push_back(stamp(OP_SUB, 1, 1, 4095, 5, 0, 0, 5));
      queue_random(300);
      settings = 1;

      for (int i = 0; i < 7; i++) begin
         case (i)
            0: begin lo = 0;    hi = 4095; end
            1: begin lo = 1999; hi = 2001; end
            2: begin lo = 3000; hi = 1000; end
            3: begin lo = 4095; hi = 4095; end
            4: begin lo = 0;    hi = 0;    end
            5: begin lo = $urandom_range(4095); hi = $urandom_range(4095, lo); end
            default: begin lo = $urandom_range(4095); hi = $urandom_range(4095); end
         endcase
         drain();
         write_csr(CSR_MIN_YEAR, lo);
         write_csr(CSR_MAX_YEAR, hi);
         settings++;
         if (i == 0) begin
            // year wrap both ways, year zero as a leap year, century rule
            datetimes_to_send.push_back(stamp(OP_ADD, 31, 12, 4095, 23, 59, 59, 1));
            datetimes_to_send.push_back(stamp(OP_SUB, 1, 1, 0, 0, 0, 0, 1));
            datetimes_to_send.push_back(stamp(OP_ADD, 29, 2, 0, 0, 0, 0, 86400));
            datetimes_to_send.push_back(stamp(OP_ADD, 29, 2, 2100, 0, 0, 0, 1));
            datetimes_to_send.push_back(stamp(OP_SUB, 1, 3, 2400, 0, 0, 0, 86400));
         end
         queue_random(250);
      end

      drain();
      repeat (LATENCY * 2) @(posedge clock);
      if (shifted_due.size() != 0) begin
         errors += shifted_due.size();
         $display("ERROR: %0d results never arrived", shifted_due.size());
      end
      $display("Covered %0d requests and %0d checked results over %0d year-bound settings,",
               sent, checked, settings);
      $display("with %0d results flagging invalid input.", rejected);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/cdo_pkg.sv
hdl/cdo_tod_split.sv
hdl/calendar_datetime_offset.sv
tb/sv/tb_calendar_datetime_offset.sv
